// ===== rtl/kds_pkg.sv =====
// Shared types and constants of the delimiter splitter.
package kds_pkg;

  // Longest delimiter the matcher handles.
  localparam int MaxDelim = 8;

  // Configuration port.
  localparam int CfgIndexW = 8;
  typedef logic [CfgIndexW-1:0] cfg_index_t;
  localparam cfg_index_t RegDelimBytes  = cfg_index_t'(0);
  localparam cfg_index_t RegDelimLength = cfg_index_t'(1);

  // Command queue between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Border table: entry [h][t] is set when the first t delimiter bytes equal
  // the last t of the h held bytes, so a new byte may extend to length t+1.
  typedef logic [MaxDelim-1:0][MaxDelim-1:0] border_tbl_t;

  // Configuration view handed to the front and back.
  typedef struct packed {
    logic [8*MaxDelim-1:0] pattern;
    logic [3:0]            len;     // clamped to 1..MaxDelim
    border_tbl_t           tbl;
    logic                  busy;    // table being rebuilt, hold input
    logic                  clear;   // register write, drop held bytes
  } cfg_info_t;

  // One classified item: emit cnt bytes of (held prefix, data), then a marker.
  typedef struct packed {
    logic [2:0] held;
    logic [7:0] data;
    logic [3:0] cnt;
    logic       marker;
  } desc_t;

endpackage

// ===== rtl/kmp_delimiter_splitter_top.sv =====
// Top level of the delimiter splitter: config, front, queue and back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_push / in_full      | in_data_byte, in_final_byte
//  result   | out_pop / out_empty    | out_kind, out_out_byte, out_last_of_run
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The front takes one input item per cycle while the four-entry command
// queue has room and no table rebuild is under way; the back emits one
// result item per cycle while results are popped, ending an item's 1 to 9
// results before the next. After reset and each known register write, input
// is held off while the table rebuilds. Either side may stall independently.
module kmp_delimiter_splitter_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_final_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_kind,
  output logic [7:0]           out_out_byte,
  output logic                 out_last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  kds_pkg::cfg_index_t  cfg_index,
  input  logic [63:0]          cfg_data
);

  kds_pkg::cfg_info_t info;
  kds_pkg::desc_t     push_desc;
  kds_pkg::desc_t     pop_desc;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;

  kds_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info)
  );

  kds_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .info          (info),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (push_desc)
  );

  kds_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_desc),
    .empty (q_empty)
  );

  kds_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pattern         (info.pattern),
    .q_empty         (q_empty),
    .q_desc          (pop_desc),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== rtl/kds_cfg.sv =====
// Configuration registers and border table of the delimiter splitter.
module kds_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  kds_pkg::cfg_index_t    cfg_index,
  input  logic [63:0]            cfg_data,
  output kds_pkg::cfg_info_t     info
);

  logic [63:0]           delim_r;
  logic [3:0]            len_r;
  logic                  busy_r;
  kds_pkg::border_tbl_t  tbl_r;
  kds_pkg::border_tbl_t  tbl_nxt;
  logic                  wr_bytes;
  logic                  wr_len;
  logic [3:0]            len_clamped;

  assign cfg_ready = 1'b1;
  assign wr_bytes  = cfg_valid && (cfg_index == kds_pkg::RegDelimBytes);
  assign wr_len    = cfg_valid && (cfg_index == kds_pkg::RegDelimLength);

  // Hold registers; flag a table rebuild after any known write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= '0;
      len_r   <= 4'd1;
      busy_r  <= 1'b1;
    end else begin
      if (wr_bytes) delim_r <= cfg_data;
      if (wr_len)   len_r   <= cfg_data[3:0];
      busy_r <= wr_bytes || wr_len;
    end
  end

  // Rebuild the border table from the current pattern every cycle.
  always_ff @(posedge clk) begin
    tbl_r <= tbl_nxt;
  end

  // Compare the prefix of t bytes against the tail of h held bytes.
  always_comb begin
    logic ok;
    tbl_nxt = '0;
    for (int h = 0; h < kds_pkg::MaxDelim; h++) begin
      for (int t = 0; t < kds_pkg::MaxDelim; t++) begin
        ok = (t <= h);
        for (int i = 0; i < kds_pkg::MaxDelim; i++) begin
          if (t <= h && i < t) begin
            ok = ok && (delim_r[8*i +: 8] == delim_r[8*(h-t+i) +: 8]);
          end
        end
        tbl_nxt[h][t] = ok;
      end
    end
  end

  // Clamp the length into 1..MaxDelim.
  always_comb begin
    if (len_r == 4'd0) begin
      len_clamped = 4'd1;
    end else if (len_r > 4'(kds_pkg::MaxDelim)) begin
      len_clamped = 4'(kds_pkg::MaxDelim);
    end else begin
      len_clamped = len_r;
    end
  end

  assign info.pattern = delim_r;
  assign info.len     = len_clamped;
  assign info.tbl     = tbl_r;
  assign info.busy    = busy_r;
  assign info.clear   = wr_bytes || wr_len;

endmodule

// ===== rtl/kds_front.sv =====
// Front end: accepts input items, runs the matcher and queues emit commands.
module kds_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_data_byte,
  input  logic                in_final_byte,
  input  kds_pkg::cfg_info_t  info,
  input  logic                q_full,
  output logic                q_push,
  output kds_pkg::desc_t      q_desc
);

  logic [2:0] ml_r;
  logic [2:0] ml_nxt;
  logic       seg_r;
  logic       seg_nxt;
  logic       accept;
  logic [3:0] jn;
  logic [3:0] held_plus;
  logic [3:0] cnt;
  logic       marker;

  assign in_full = q_full || info.busy;
  assign accept  = in_push && !in_full;

  // Find the longest prefix that the held bytes plus the new byte end in.
  always_comb begin
    jn = 4'd0;
    for (int t = 0; t < kds_pkg::MaxDelim; t++) begin
      if (info.tbl[ml_r][t] && (in_data_byte == info.pattern[8*t +: 8])) begin
        jn = 4'(t + 1);
      end
    end
  end

  // Classify: release bytes, drop a full match, close the segment.
  always_comb begin
    logic seg_mid;
    held_plus = {1'b0, ml_r} + 4'd1;
    cnt       = 4'd0;
    marker    = 1'b0;
    seg_nxt   = seg_r;
    ml_nxt    = ml_r;
    seg_mid   = seg_r;
    if (jn == info.len) begin
      marker  = seg_r;
      seg_nxt = 1'b0;
      ml_nxt  = 3'd0;
    end else begin
      cnt     = in_final_byte ? held_plus : (held_plus - jn);
      seg_mid = seg_r || (cnt != 4'd0);
      marker  = in_final_byte && seg_mid;
      seg_nxt = in_final_byte ? 1'b0 : seg_mid;
      ml_nxt  = in_final_byte ? 3'd0 : jn[2:0];
    end
  end

  assign q_push        = accept && ((cnt != 4'd0) || marker);
  assign q_desc.held   = ml_r;
  assign q_desc.data   = in_data_byte;
  assign q_desc.cnt    = cnt;
  assign q_desc.marker = marker;

  // Advance match state; a register write drops any held bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_r  <= 3'd0;
      seg_r <= 1'b0;
    end else begin
      if (accept) begin
        ml_r  <= ml_nxt;
        seg_r <= seg_nxt;
      end
      if (info.clear) ml_r <= 3'd0;
    end
  end

endmodule

// ===== rtl/kds_queue.sv =====
// Short command queue between front and back.
module kds_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kds_pkg::desc_t  wdata,
  output logic            full,
  input  logic            pop,
  output kds_pkg::desc_t  rdata,
  output logic            empty
);

  kds_pkg::desc_t                mem [kds_pkg::QDepth];
  logic [kds_pkg::QPtrW-1:0]     wr_ptr_r;
  logic [kds_pkg::QPtrW-1:0]     rd_ptr_r;
  logic [kds_pkg::QPtrW:0]       count_r;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count_r == (kds_pkg::QPtrW+1)'(kds_pkg::QDepth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Store entries.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/kds_back.sv =====
// Back end: expands each queued command into result items.
module kds_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [63:0]           pattern,
  input  logic                  q_empty,
  input  kds_pkg::desc_t        q_desc,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_kind,
  output logic [7:0]            out_out_byte,
  output logic                  out_last_of_run
);

  kds_pkg::desc_t cur_r;
  logic           valid_r;
  logic [3:0]     k_r;
  logic [3:0]     total;
  logic           last;
  logic           load;

  assign total = cur_r.cnt + {3'd0, cur_r.marker};
  assign last  = ((k_r + 4'd1) == total);
  assign load  = !valid_r || (out_pop && last);
  assign q_pop = load && !q_empty;

  // Present the current result: held prefix bytes, the new byte, a marker.
  always_comb begin
    out_kind = cur_r.marker && (k_r == cur_r.cnt);
    if (out_kind) begin
      out_out_byte = 8'd0;
    end else if (k_r < {1'b0, cur_r.held}) begin
      out_out_byte = pattern[8*k_r[2:0] +: 8];
    end else begin
      out_out_byte = cur_r.data;
    end
  end

  assign out_empty       = !valid_r;
  assign out_last_of_run = last;

  // Step through results; take the next command after the last one goes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= 4'd0;
    end else if (load) begin
      valid_r <= !q_empty;
      k_r     <= 4'd0;
    end else if (out_pop) begin
      k_r <= k_r + 4'd1;
    end
  end

  // Hold the command payload.
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_desc;
  end

endmodule

// ===== rtl/kds_checker.sv =====
// Port-level checks of the delimiter splitter, bound to the top level.
module kds_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic                 out_kind,
  input logic [7:0]           out_out_byte,
  input logic                 out_last_of_run,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input kds_pkg::cfg_index_t  cfg_index
);

  logic prev_marker_r;

  // Track whether the last result item taken was a marker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_marker_r <= 1'b0;
    end else if (out_pop && !out_empty) begin
      prev_marker_r <= out_kind;
    end
  end

  // A marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind) |-> (out_out_byte == 8'd0))
    else $error("segment marker with nonzero byte");

  // A marker always ends the run of its input item.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind) |-> out_last_of_run)
    else $error("segment marker not last of run");

  // Empty segments are suppressed: no two markers in a row.
  a_no_double_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind && prev_marker_r) |-> 1'b0)
    else $error("two segment markers in a row");

  // A known register write holds off input while the table rebuilds.
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready &&
     (cfg_index == kds_pkg::RegDelimBytes || cfg_index == kds_pkg::RegDelimLength))
    |=> in_full)
    else $error("input accepted during table rebuild");

  // A waiting result holds until taken.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
    (!out_empty && $stable(out_kind) && $stable(out_out_byte) && $stable(out_last_of_run)))
    else $error("waiting result changed");

endmodule

bind kmp_delimiter_splitter_top kds_checker u_kds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_kind        (out_kind),
  .out_out_byte    (out_out_byte),
  .out_last_of_run (out_last_of_run),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .cfg_index       (cfg_index)
);

// ===== tb/tb.sv =====
// Self-checking testbench of the KMP delimiter splitter: queued driver, checking monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit  = 1000;
  localparam int DrainCycles    = 12;
  localparam int LongHoldCycles = 150;
  localparam int MaxReports     = 30;

  // Result kinds.
  localparam logic KindData   = 1'b0;
  localparam logic KindMarker = 1'b1;

  // Index that maps to no register.
  localparam kds_pkg::cfg_index_t RegUnused = kds_pkg::cfg_index_t'(8'hFF);

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } text_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } split_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [7:0]          in_data_byte = 8'h00;
  logic                in_final_byte = 1'b0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic                out_kind;
  logic [7:0]          out_out_byte;
  logic                out_last_of_run;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  kds_pkg::cfg_index_t cfg_index = '0;
  logic [63:0]         cfg_data = '0;

  kmp_delimiter_splitter_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // Splitter state mirrored by the predictor.
  logic [63:0]   dl_pattern = '0;
  logic [3:0]    dl_len_reg = 4'd1;
  logic [2:0]    border_tbl [kds_pkg::MaxDelim];
  int unsigned   held_count;
  bit            segment_open;
  split_result_t pending_results [$];
  text_item_t    text_queue [$];

  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned error_count = 0;
  int unsigned send_max_gap = 0;
  int unsigned recv_max_gap = 0;
  bit          hold_request = 0;
  bit          hold_served = 0;

  function automatic int unsigned delim_len();
    int unsigned m;
    m = dl_len_reg;
    if (m < 1) m = 1;
    if (m > kds_pkg::MaxDelim) m = kds_pkg::MaxDelim;
    return m;
  endfunction

  function automatic logic [7:0] delim_byte(int unsigned i);
    return dl_pattern[8*(i % kds_pkg::MaxDelim) +: 8];
  endfunction

  // Rebuild the failure table and drop any held partial match.
  function automatic void rebuild_borders();
    int unsigned m;
    int unsigned j;
    m = delim_len();
    j = 0;
    for (int k = 0; k < kds_pkg::MaxDelim; k++) border_tbl[k] = '0;
    for (int unsigned i = 1; i < m; i++) begin
      while (j > 0 && delim_byte(j) != delim_byte(i)) j = border_tbl[j-1];
      if (delim_byte(j) == delim_byte(i)) j++;
      border_tbl[i] = 3'(j);
    end
    held_count = 0;
  endfunction

  function automatic void apply_config(kds_pkg::cfg_index_t idx, logic [63:0] val);
    if (idx == kds_pkg::RegDelimBytes) dl_pattern = val;
    else if (idx == kds_pkg::RegDelimLength) dl_len_reg = val[3:0];
    else return;
    rebuild_borders();
  endfunction

  // Work out the results one accepted text byte releases.
  function automatic void split_predict(logic [7:0] c, logic fin);
    split_result_t run [$];
    int unsigned   m;
    int unsigned   old_held;
    int unsigned   j;
    int unsigned   release_cnt;
    m = delim_len();
    old_held = held_count;
    j = old_held;
    if (j >= m) j = 0;
    while (j > 0 && c != delim_byte(j)) j = border_tbl[j-1];
    if (c == delim_byte(j)) j++;
    if (j == m) begin
      // full delimiter: drop it, close the segment if it has bytes
      if (segment_open) run.insert(run.size(), split_result_t'{KindMarker, 8'h00, 1'b0});
      segment_open = 0;
      j = 0;
    end else begin
      // leading bytes that no longer form a partial match leave
      release_cnt = old_held + 1 - j;
      for (int unsigned k = 0; k < release_cnt; k++)
        run.insert(run.size(),
                   split_result_t'{KindData, (k < old_held) ? delim_byte(k) : c, 1'b0});
      if (release_cnt > 0) segment_open = 1;
      if (fin) begin
        for (int unsigned k = 0; k < j; k++)
          run.insert(run.size(), split_result_t'{KindData, delim_byte(k), 1'b0});
        if (j > 0) segment_open = 1;
        j = 0;
      end
    end
    if (fin) begin
      if (segment_open) run.insert(run.size(), split_result_t'{KindMarker, 8'h00, 1'b0});
      segment_open = 0;
      j = 0;
    end
    held_count = j;
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[k]) pending_results.insert(pending_results.size(), run[k]);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MaxReports) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Driver: offer queued text bytes with a random gap after each item.
  always @(posedge clk) begin
    text_item_t nxt;
    logic       push_n;
    int unsigned send_wait;
    if (!rst_n) begin
      in_push <= 1'b0;
      send_wait = 0;
    end else begin
      push_n = in_push;
      if (in_push && !in_full) begin
        split_predict(in_data_byte, in_final_byte);
        items_sent++;
        push_n = 1'b0;
      end
      if (!push_n) begin
        if (send_wait > 0) send_wait--;
        else if (text_queue.size() > 0) begin
          nxt = text_queue.pop_front();
          in_data_byte  <= nxt.data;
          in_final_byte <= nxt.fin;
          push_n = 1'b1;
          send_wait = $urandom_range(0, send_max_gap);
        end
      end
      in_push <= push_n;
    end
  end

  // Monitor: check each popped item against the oldest expectation.
  always @(posedge clk) begin
    split_result_t want;
    int unsigned   recv_wait;
    int unsigned   rx_hold;
    if (!rst_n) begin
      out_pop <= 1'b0;
      recv_wait = 0;
      rx_hold = 0;
    end else begin
      if (hold_request && !hold_served) begin
        rx_hold = LongHoldCycles;
        hold_served = 1;
      end
      if (out_pop && !out_empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0b byte=%02h last=%0b",
                                    out_kind, out_out_byte, out_last_of_run));
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0b, expected %0b", out_kind, want.kind));
          if (out_out_byte !== want.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_out_byte, want.data));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      out_last_of_run, want.last));
        end
        recv_wait = $urandom_range(0, recv_max_gap);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_pop <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    int unsigned idle_cycles;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(kds_pkg::cfg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(logic [7:0] data, logic fin);
    text_queue.insert(text_queue.size(), text_item_t'{data, fin});
    items_queued++;
  endtask

  // Hold until every item is in, every result is out and the pipe is drained.
  task automatic settle();
    while (items_sent != items_queued) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Queue text built mostly from whole and broken delimiter copies.
  task automatic queue_text(int unsigned count, logic [7:0] a0, logic [7:0] a1);
    int unsigned m;
    int unsigned n;
    int unsigned pick;
    int unsigned chunk;
    logic [7:0]  b;
    m = delim_len();
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) chunk = m;
      else if (pick < 5) chunk = $urandom_range(1, m);
      else chunk = 1;
      for (int unsigned k = 0; k < chunk && n < count; k++) begin
        if (pick < 5) b = delim_byte(k);
        else if (pick < 8) b = $urandom_range(0, 1) ? a0 : a1;
        else b = 8'($urandom_range(0, 255));
        queue_item(b, $urandom_range(0, 11) == 0);
        n++;
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 15;
    endcase
  endfunction

  initial begin
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [63:0] pat;
    logic [63:0] len_word;
    int unsigned count;
    rebuild_borders();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Default delimiter is a single zero byte.
    queue_item(8'h00, 1'b0);   // match with no open segment
    queue_item(8'h00, 1'b0);   // empty piece, suppressed
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b0);   // closes the segment
    queue_item(8'h5A, 1'b1);   // final byte closes the segment
    queue_item(8'h00, 1'b1);   // match on final byte, nothing open
    queue_item(8'hA5, 1'b0);
    queue_item(8'h00, 1'b1);   // match on final byte, segment open
    settle();

    // Self-overlapping delimiter "aba".
    write_reg(kds_pkg::RegDelimBytes, 64'h0000_0000_0061_6261);
    write_reg(kds_pkg::RegDelimLength, 64'd3);
    send_max_gap = 3;
    recv_max_gap = 3;
    queue_item(8'h61, 1'b0);
    queue_item(8'h62, 1'b0);
    queue_item(8'h61, 1'b0);   // match at start of text
    queue_item(8'h78, 1'b0);
    queue_item(8'h61, 1'b0);
    queue_item(8'h62, 1'b0);
    queue_item(8'h61, 1'b0);   // match, no overlap allowed
    queue_item(8'h62, 1'b0);
    queue_item(8'h61, 1'b0);
    queue_item(8'h63, 1'b0);   // mismatch releases the held byte
    queue_item(8'h61, 1'b0);
    queue_item(8'h62, 1'b0);
    queue_item(8'h78, 1'b1);   // final byte flushes held bytes
    queue_item(8'h71, 1'b0);
    queue_item(8'h61, 1'b0);
    queue_item(8'h62, 1'b0);
    queue_item(8'h61, 1'b1);   // match on final byte
    settle();

    // Random phases, one delimiter setting each.
    for (int p = 0; p < 8; p++) begin
      a0 = 8'($urandom);
      a1 = 8'($urandom);
      pat = '0;
      for (int i = 0; i < kds_pkg::MaxDelim; i++)
        pat[8*i +: 8] = $urandom_range(0, 1) ? a0 : a1;
      len_word = {$urandom, $urandom};
      len_word[3:0] = 4'($urandom_range(1, 8));
      send_max_gap = pick_gap();
      recv_max_gap = pick_gap();
      count = 22;
      case (p)
        0: begin
          pat = '1;
          a0 = 8'hFF;
          len_word[3:0] = 4'd15;   // above range, acts as the longest
        end
        1: len_word[3:0] = 4'd0;   // zero, acts as one byte
        2: begin
          // fill the block against a stalled receiver
          len_word[3:0] = 4'd2;
          send_max_gap = 0;
          recv_max_gap = 0;
          count = 30;
        end
        3: len_word[3:0] = 4'd1;
        4: begin
          send_max_gap = 0;
          recv_max_gap = 0;
        end
        5: pat = {$urandom, $urandom};
        6: len_word[3:0] = 4'd8;
        default: begin
          send_max_gap = 15;
          recv_max_gap = 15;
        end
      endcase
      write_reg(kds_pkg::RegDelimBytes, pat);
      write_reg(kds_pkg::RegDelimLength, len_word);
      if (p == 1) write_reg(RegUnused, {$urandom, $urandom});
      if (p == 2) hold_request = 1;
      queue_text(count, a0, a1);
      settle();
    end

    $display("Run covered %0d text bytes, %0d result items, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("over 10 delimiter settings; %0d mismatches counted", error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
